// File: rtl/core/windowed_association_rule_matcher_unit_macros.svh
// Assertion macros for the windowed association rule matcher.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef WINDOWED_ASSOCIATION_RULE_MATCHER_UNIT_MACROS_SVH
`define WINDOWED_ASSOCIATION_RULE_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wrm_pkg.sv
// Shared types, codes and helpers of the windowed association rule matcher.
// No dependencies; used by wrm_rule_cell and the top level.
package wrm_pkg;

    localparam int unsigned PATTERN_IDS_DEF = 1024;
    localparam int unsigned NUM_RULES_DEF   = 64;
    localparam int unsigned MAX_ANTE_DEF    = 8;

    localparam int unsigned PID_W    = 16;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned RIDX_W   = 6;
    localparam int unsigned CONF_W   = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned M_TDATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_INFO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_WARN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CRIT  = 2'd3;

    localparam logic [TS_W-1:0]   WINDOW_RST   = 32'd60;
    localparam logic [CONF_W-1:0] THR_INFO_RST = 16'd16384;
    localparam logic [CONF_W-1:0] THR_WARN_RST = 16'd32768;
    localparam logic [CONF_W-1:0] THR_CRIT_RST = 16'd49152;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVENT  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATE    = 3'd0,
        STAT_NOMINAL   = 3'd1,
        STAT_INFO      = 3'd2,
        STAT_WARNING   = 3'd3,
        STAT_CRITICAL  = 3'd4,
        STAT_BAD_ID    = 3'd5,
        STAT_RULE_FULL = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EXPIRE,
        OP_MARK,
        OP_LOAD,
        OP_CLEAR
    } cell_op_t;

    typedef enum logic [3:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_SWEEP,
        FSM_SCAN,
        FSM_MARK,
        FSM_CHAIN,
        FSM_COMMIT,
        FSM_LOAD,
        FSM_DONE
    } fsm_t;

    // request broadcast to every rule cell
    typedef struct packed {
        cell_op_t          op;
        logic [PID_W-1:0]  pattern;
        logic [RIDX_W-1:0] rule_index;
        logic [CONF_W-1:0] conf;
    } cell_cmd_t;

    // running result passed cell to cell
    typedef struct packed {
        logic              any;
        logic [CONF_W-1:0] max_conf;
    } chain_t;

    function automatic status_t grade(input logic [CONF_W-1:0] maxc,
                                      input logic [CONF_W-1:0] thr_info,
                                      input logic [CONF_W-1:0] thr_warn,
                                      input logic [CONF_W-1:0] thr_crit);
        status_t s;
        if (maxc == '0)            s = STAT_UPDATE;
        else if (maxc < thr_info)  s = STAT_NOMINAL;
        else if (maxc < thr_warn)  s = STAT_INFO;
        else if (maxc < thr_crit)  s = STAT_WARNING;
        else                       s = STAT_CRITICAL;
        return s;
    endfunction

endpackage

// File: rtl/core/windowed_association_rule_matcher_unit.sv
// Top level of the windowed association rule matcher.
// Depends on wrm_pkg, wrm_window_mem, wrm_rule_cell and the assertion macro header.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: kind; tdata: pattern_id, ts, rule, conf
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: alert_time, max_conf
//  cfg_    | in  | cfg_we             | cfg_idx, cfg_wdata
//
// Event: accept, window scan over every entry (one memory read a cycle), mark, the
//   result ripples down the cell chain, then commit and result. A load passes the load
//   state before the result; a bad event or an unused kind goes straight to it.
// Reset (and a clear request) sweeps every entry of the window memory; no request is
//   taken meanwhile.
// One request at a time; a finished result waits in the output register while the
//   next request is accepted, and a result stalls only behind an untaken one.
`include "windowed_association_rule_matcher_unit_macros.svh"

module windowed_association_rule_matcher_unit #(
    parameter int unsigned PATTERN_IDS     = wrm_pkg::PATTERN_IDS_DEF,
    parameter int unsigned NUM_RULES       = wrm_pkg::NUM_RULES_DEF,
    parameter int unsigned MAX_ANTECEDENTS = wrm_pkg::MAX_ANTE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] pattern_id, [47:16] timestamp_sec, [53:48] rule_index,
    // [69:54] confidence, [71:70] zero
    input  logic [wrm_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] kind
    input  logic [wrm_pkg::KIND_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] alert_time, [47:32] max_confidence
    output logic [wrm_pkg::M_TDATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [wrm_pkg::STATUS_W-1:0]       m_tuser,
    input  logic                               cfg_we,
    input  logic [wrm_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [wrm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int unsigned AW      = (PATTERN_IDS > 1) ? $clog2(PATTERN_IDS) : 1;
    localparam int unsigned CNT_W   = AW + 1;
    localparam int unsigned CHAIN_W = $clog2(NUM_RULES + 1);
    localparam int unsigned MEM_W   = wrm_pkg::TS_W + 1;
    localparam int unsigned PIDX_W  = wrm_pkg::PID_W + 1;

    // config registers
    logic [wrm_pkg::TS_W-1:0]   window_reg;
    logic [wrm_pkg::CONF_W-1:0] thr_info_reg, thr_warn_reg, thr_crit_reg;

    // latched request
    wrm_pkg::kind_t             kind_reg;
    logic [wrm_pkg::PID_W-1:0]  pid_reg;
    logic [wrm_pkg::TS_W-1:0]   ts_reg;
    logic [wrm_pkg::RIDX_W-1:0] ridx_reg;
    logic [wrm_pkg::CONF_W-1:0] conf_reg;

    wrm_pkg::fsm_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [CHAIN_W-1:0] chain_cnt_reg, chain_cnt_next;

    wrm_pkg::status_t           res_status_reg, res_status_next;
    logic [wrm_pkg::TS_W-1:0]   res_time_reg, res_time_next;
    logic [wrm_pkg::CONF_W-1:0] res_conf_reg, res_conf_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    wrm_pkg::status_t           out_status_reg;
    logic [wrm_pkg::TS_W-1:0]   out_time_reg;
    logic [wrm_pkg::CONF_W-1:0] out_conf_reg;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [MEM_W-1:0] mem_wdata, mem_rdata;

    wrm_pkg::cell_cmd_t cmd;
    wrm_pkg::chain_t    chain_w [NUM_RULES + 1];
    logic [NUM_RULES-1:0] full_vec;
    logic               full_any;
    wrm_pkg::chain_t    chain_last;

    logic                     s_accept;
    logic                     out_free;
    logic                     pid_bad;
    logic                     ridx_bad;
    logic                     scan_done;
    logic                     expire;
    logic [wrm_pkg::TS_W-1:0] ls;
    logic [wrm_pkg::TS_W-1:0] age;

    assign s_tready  = (state_reg == wrm_pkg::FSM_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pid_bad   = (PIDX_W'(pid_reg) >= PIDX_W'(PATTERN_IDS));
    assign ridx_bad  = (32'(ridx_reg) >= 32'(NUM_RULES));
    assign scan_done = (cnt_reg == CNT_W'(PATTERN_IDS));
    assign full_any  = |full_vec;
    assign chain_last = chain_w[NUM_RULES];

    // expiry test on the word read for rd_addr_reg
    assign ls     = mem_rdata[wrm_pkg::TS_W-1:0];
    assign age    = ts_reg - ls;
    assign expire = rd_valid_reg && mem_rdata[wrm_pkg::TS_W] && (ts_reg >= ls)
                    && (age > window_reg);

    wrm_window_mem #(
        .DEPTH (PATTERN_IDS),
        .AW    (AW),
        .DW    (MEM_W)
    ) u_window_mem (
        .aclk      (aclk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

    assign chain_w[0] = '0;

    for (genvar i = 0; i < NUM_RULES; i++) begin : g_cell
        wrm_rule_cell #(
            .MAX_ANTE (MAX_ANTECEDENTS),
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .chain_in  (chain_w[i]),
            .chain_out (chain_w[i + 1]),
            .full_sel  (full_vec[i])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wrm_pkg::FSM_INIT: begin
                if (cnt_reg == CNT_W'(PATTERN_IDS - 1)) state_next = wrm_pkg::FSM_IDLE;
            end
            wrm_pkg::FSM_IDLE: begin
                if (s_accept) begin
                    unique case (wrm_pkg::kind_t'(s_tuser))
                        wrm_pkg::KIND_EVENT: begin
                            if (PIDX_W'(s_tdata[15:0]) >= PIDX_W'(PATTERN_IDS)) begin
                                state_next = wrm_pkg::FSM_DONE;
                            end else begin
                                state_next = wrm_pkg::FSM_SCAN;
                            end
                        end
                        wrm_pkg::KIND_LOAD:  state_next = wrm_pkg::FSM_LOAD;
                        wrm_pkg::KIND_CLEAR: state_next = wrm_pkg::FSM_SWEEP;
                        default:             state_next = wrm_pkg::FSM_DONE;
                    endcase
                end
            end
            wrm_pkg::FSM_SWEEP: begin
                if (cnt_reg == CNT_W'(PATTERN_IDS - 1)) state_next = wrm_pkg::FSM_DONE;
            end
            wrm_pkg::FSM_SCAN: begin
                if (scan_done && !rd_valid_reg) state_next = wrm_pkg::FSM_MARK;
            end
            wrm_pkg::FSM_MARK:   state_next = wrm_pkg::FSM_CHAIN;
            wrm_pkg::FSM_CHAIN: begin
                if (chain_cnt_reg == CHAIN_W'(NUM_RULES - 1)) state_next = wrm_pkg::FSM_COMMIT;
            end
            wrm_pkg::FSM_COMMIT: state_next = wrm_pkg::FSM_DONE;
            wrm_pkg::FSM_LOAD:   state_next = wrm_pkg::FSM_DONE;
            wrm_pkg::FSM_DONE: begin
                if (out_free) state_next = wrm_pkg::FSM_IDLE;
            end
            default:             state_next = wrm_pkg::FSM_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        cnt_next        = cnt_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        chain_cnt_next  = chain_cnt_reg;
        res_status_next = res_status_reg;
        res_time_next   = res_time_reg;
        res_conf_next   = res_conf_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_we          = 1'b0;
        mem_waddr       = rd_addr_reg;
        mem_wdata       = '0;
        mem_raddr       = cnt_reg[AW-1:0];
        cmd.op          = wrm_pkg::OP_NONE;
        cmd.pattern     = pid_reg;
        cmd.rule_index  = ridx_reg;
        cmd.conf        = conf_reg;
        unique case (state_reg)
            wrm_pkg::FSM_INIT, wrm_pkg::FSM_SWEEP: begin
                // zero every entry; leaving the window also drops every mark
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                cmd.op    = wrm_pkg::OP_CLEAR;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            wrm_pkg::FSM_IDLE: begin
                cnt_next        = '0;
                chain_cnt_next  = '0;
                res_status_next = wrm_pkg::STAT_UPDATE;
                res_time_next   = '0;
                res_conf_next   = '0;
                if (s_accept && (wrm_pkg::kind_t'(s_tuser) == wrm_pkg::KIND_EVENT)
                        && (PIDX_W'(s_tdata[15:0]) >= PIDX_W'(PATTERN_IDS))) begin
                    res_status_next = wrm_pkg::STAT_BAD_ID;
                end
            end
            wrm_pkg::FSM_SCAN: begin
                if (!scan_done) begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                if (expire) begin
                    mem_we      = 1'b1;
                    cmd.op      = wrm_pkg::OP_EXPIRE;
                    cmd.pattern = wrm_pkg::PID_W'(rd_addr_reg);
                end
            end
            wrm_pkg::FSM_MARK: begin
                cmd.op = wrm_pkg::OP_MARK;
            end
            wrm_pkg::FSM_CHAIN: begin
                chain_cnt_next = chain_cnt_reg + CHAIN_W'(1);
            end
            wrm_pkg::FSM_COMMIT: begin
                if (chain_last.any) begin
                    mem_we          = 1'b1;
                    mem_waddr       = pid_reg[AW-1:0];
                    mem_wdata       = {1'b1, ts_reg};
                    res_conf_next   = chain_last.max_conf;
                    res_status_next = wrm_pkg::grade(chain_last.max_conf, thr_info_reg,
                                                     thr_warn_reg, thr_crit_reg);
                    res_time_next   = (chain_last.max_conf != '0) ? ts_reg : '0;
                end
            end
            wrm_pkg::FSM_LOAD: begin
                if (pid_bad || ridx_bad) begin
                    res_status_next = wrm_pkg::STAT_BAD_ID;
                end else begin
                    cmd.op = wrm_pkg::OP_LOAD;
                    if (full_any) res_status_next = wrm_pkg::STAT_RULE_FULL;
                end
            end
            wrm_pkg::FSM_DONE: begin
                if (out_free) m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wrm_pkg::FSM_INIT;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            chain_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            window_reg    <= wrm_pkg::WINDOW_RST;
            thr_info_reg  <= wrm_pkg::THR_INFO_RST;
            thr_warn_reg  <= wrm_pkg::THR_WARN_RST;
            thr_crit_reg  <= wrm_pkg::THR_CRIT_RST;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            chain_cnt_reg <= chain_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    wrm_pkg::CFG_WINDOW:   window_reg   <= cfg_wdata;
                    wrm_pkg::CFG_THR_INFO: thr_info_reg <= cfg_wdata[wrm_pkg::CONF_W-1:0];
                    wrm_pkg::CFG_THR_WARN: thr_warn_reg <= cfg_wdata[wrm_pkg::CONF_W-1:0];
                    wrm_pkg::CFG_THR_CRIT: thr_crit_reg <= cfg_wdata[wrm_pkg::CONF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg    <= rd_addr_next;
        res_status_reg <= res_status_next;
        res_time_reg   <= res_time_next;
        res_conf_reg   <= res_conf_next;
        if (s_accept) begin
            kind_reg <= wrm_pkg::kind_t'(s_tuser);
            pid_reg  <= s_tdata[15:0];
            ts_reg   <= s_tdata[47:16];
            ridx_reg <= s_tdata[53:48];
            conf_reg <= s_tdata[69:54];
        end
        if (state_reg == wrm_pkg::FSM_DONE && out_free) begin
            out_status_reg <= res_status_reg;
            out_time_reg   <= res_time_reg;
            out_conf_reg   <= res_conf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_conf_reg, out_time_reg};

    // alert time only rides with a graded level
    `WRM_ASSERT_IMPL(a_time_only_on_alert, aclk, aresetn, m_tvalid_reg && (out_status_reg == wrm_pkg::STAT_UPDATE || out_status_reg == wrm_pkg::STAT_BAD_ID || out_status_reg == wrm_pkg::STAT_RULE_FULL), out_time_reg == '0, "alert time set without a level")
    // zero confidence never grades to a level
    `WRM_ASSERT_IMPL(a_zero_conf_no_level, aclk, aresetn, m_tvalid_reg && out_conf_reg == '0, out_status_reg == wrm_pkg::STAT_UPDATE || out_status_reg == wrm_pkg::STAT_BAD_ID || out_status_reg == wrm_pkg::STAT_RULE_FULL, "level graded from zero confidence")
    // one request in flight
    `WRM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_accept, !s_tready, "request taken while busy")
    // scan counter never runs past the table
    `WRM_ASSERT_IMPL(a_scan_bound, aclk, aresetn, state_reg == wrm_pkg::FSM_SCAN, cnt_reg <= CNT_W'(PATTERN_IDS), "window scan overran")
    // the load state is only reached from a load request
    `WRM_ASSERT_IMPL(a_load_kind, aclk, aresetn, state_reg == wrm_pkg::FSM_LOAD, kind_reg == wrm_pkg::KIND_LOAD, "load state without load request")

endmodule

// File: rtl/core/wrm_window_mem.sv
// Pattern window store: {in_window, last_seen} per pattern id.
// One write port, one registered read port; uses no package items.
module wrm_window_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 33
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata_reg
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

endmodule

// File: rtl/core/wrm_rule_cell.sv
// One rule of the matcher: antecedent slots, marks, size, hit count, confidence.
// Depends on wrm_pkg; instantiated as a chain by the top level.
module wrm_rule_cell #(
    parameter int unsigned MAX_ANTE = wrm_pkg::MAX_ANTE_DEF,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wrm_pkg::cell_cmd_t cmd,
    input  wrm_pkg::chain_t    chain_in,
    output wrm_pkg::chain_t    chain_out,
    output logic               full_sel
);

    localparam int unsigned SZ_W   = $clog2(MAX_ANTE + 1);
    localparam int unsigned SLOT_W = (MAX_ANTE > 1) ? $clog2(MAX_ANTE) : 1;

    logic [wrm_pkg::PID_W-1:0]  pat_reg [MAX_ANTE];
    logic [MAX_ANTE-1:0]        seen_reg, seen_next;
    logic [SZ_W-1:0]            size_reg, size_next;
    logic [SZ_W-1:0]            hits_reg, hits_next;
    logic [wrm_pkg::CONF_W-1:0] conf_reg, conf_next;
    wrm_pkg::chain_t            own_reg, own_next;
    wrm_pkg::chain_t            acc_reg, acc_next;

    logic [MAX_ANTE-1:0] hit_vec;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic                sel;
    logic                is_full;
    logic [SLOT_W-1:0]   wslot;
    logic [SZ_W-1:0]     hits_mark;
    logic                do_load;

    // lowest valid slot holding the broadcast pattern
    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int k = 0; k < MAX_ANTE; k++) begin
            hit_vec[k] = (SZ_W'(k) < size_reg) && (pat_reg[k] == cmd.pattern);
        end
        for (int k = MAX_ANTE - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                found = 1'b1;
                slot  = SLOT_W'(k);
            end
        end
    end

    assign sel      = (32'(cmd.rule_index) == 32'(CELL_IDX));
    assign is_full  = (size_reg == SZ_W'(MAX_ANTE));
    assign full_sel = sel && is_full;
    assign wslot    = size_reg[SLOT_W-1:0];
    assign do_load  = (cmd.op == wrm_pkg::OP_LOAD) && sel && !is_full;
    assign hits_mark = seen_reg[slot] ? hits_reg : hits_reg + SZ_W'(1);

    always_comb begin
        seen_next = seen_reg;
        size_next = size_reg;
        hits_next = hits_reg;
        conf_next = conf_reg;
        own_next  = own_reg;
        case (cmd.op)
            wrm_pkg::OP_EXPIRE: begin
                if (found && seen_reg[slot]) begin
                    seen_next[slot] = 1'b0;
                    hits_next       = hits_reg - SZ_W'(1);
                end
            end
            wrm_pkg::OP_MARK: begin
                own_next.any      = found;
                own_next.max_conf = '0;
                if (found) begin
                    seen_next[slot] = 1'b1;
                    hits_next       = hits_mark;
                    if (hits_mark == size_reg) begin
                        // rule complete: fire and rearm
                        seen_next         = '0;
                        hits_next         = '0;
                        own_next.max_conf = conf_reg;
                    end
                end
            end
            wrm_pkg::OP_LOAD: begin
                if (do_load) begin
                    seen_next[wslot] = 1'b0;
                    size_next        = size_reg + SZ_W'(1);
                    conf_next        = cmd.conf;
                end
            end
            wrm_pkg::OP_CLEAR: begin
                seen_next = '0;
                hits_next = '0;
            end
            default: begin
            end
        endcase
    end

    // reduction ripples one cell per cycle
    always_comb begin
        acc_next.any      = chain_in.any | own_reg.any;
        acc_next.max_conf = (own_reg.max_conf > chain_in.max_conf) ? own_reg.max_conf
                                                                   : chain_in.max_conf;
    end

    assign chain_out = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            size_reg <= '0;
            hits_reg <= '0;
        end else begin
            seen_reg <= seen_next;
            size_reg <= size_next;
            hits_reg <= hits_next;
        end
    end

    always_ff @(posedge aclk) begin
        conf_reg <= conf_next;
        own_reg  <= own_next;
        acc_reg  <= acc_next;
        if (do_load) begin
            pat_reg[wslot] <= cmd.pattern;
        end
    end

endmodule
